// File: design/kwrl_pkg.sv
// Package for the keyed window rate limiter: request, response, token and
// configuration types, register indexes and a saturating increment.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package kwrl_pkg;

  localparam int CFG_IDX_W = 8;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_IDX_MAX_PER_WINDOW = cfg_idx_t'(0);
  localparam cfg_idx_t CFG_IDX_WINDOW_LENGTH  = cfg_idx_t'(1);

  localparam logic [15:0] MAX_PER_WINDOW_RST = 16'd10;
  localparam logic [63:0] WINDOW_LENGTH_RST  = 64'd1000000000;

  typedef struct packed {
    logic        is_limited;
    logic [15:0] key_domain;
    logic [15:0] key_code;
    logic [63:0] timestamp;
  } in_req_t;

  typedef struct packed {
    logic        forward;
    logic [31:0] held_back;
    logic        untracked;
    logic [31:0] total_dropped;
  } out_rsp_t;

  typedef struct packed {
    logic [15:0] max_per_window;
    logic [63:0] window_length;
  } cfg_regs_t;

  // A request travelling down the row of cells.
  typedef struct packed {
    logic        valid;
    logic        done;
    logic [31:0] key;
    logic [63:0] timestamp;
    logic        forward;
    logic [31:0] held_back;
    logic        dropped;
    logic        allocated;
  } token_t;

  function automatic logic [31:0] sat_inc32(input logic [31:0] v);
    sat_inc32 = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

endpackage

`default_nettype wire

// File: design/kwrl_cell.sv
// One table slot of the rate limiter: holds key, window start and counts,
// serves a matching request or allocates itself, then hands the request on.
// Depends on kwrl_pkg.
`default_nettype none

module kwrl_cell
  import kwrl_pkg::*;
#(
  parameter int CELL_IDX = 0,
  parameter int SU_W     = 5
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire cfg_regs_t       cfg,
  input  wire logic [SU_W-1:0] slots_used,
  input  wire token_t          tok_in,
  output token_t               tok_out
);

  logic [31:0] key_r,    key_nxt;
  logic [63:0] start_r,  start_nxt;
  logic [15:0] passed_r, passed_nxt;
  logic [31:0] supp_r,   supp_nxt;
  token_t      tok_r,    tok_nxt;

  logic        live;
  logic        used;
  logic        hit;
  logic        alloc;
  logic        restart;
  logic        limit_hit;
  logic [63:0] cur_start;
  logic [15:0] cur_passed;
  logic [31:0] cur_supp;
  logic [63:0] eff_start;
  logic [15:0] eff_passed;

  assign live  = tok_in.valid && !tok_in.done;
  assign used  = SU_W'(CELL_IDX) < slots_used;
  assign hit   = live && used && (key_r == tok_in.key);
  assign alloc = live && (slots_used == SU_W'(CELL_IDX));

  always_comb begin
    cur_start  = alloc ? 64'd0 : start_r;
    cur_passed = alloc ? 16'd0 : passed_r;
    cur_supp   = alloc ? 32'd0 : supp_r;
    restart    = (cur_passed == 16'd0) ||
                 ((tok_in.timestamp - cur_start) >= cfg.window_length);
    eff_start  = restart ? tok_in.timestamp : cur_start;
    eff_passed = restart ? 16'd0 : cur_passed;
    limit_hit  = (eff_passed == cfg.max_per_window);

    key_nxt    = key_r;
    start_nxt  = start_r;
    passed_nxt = passed_r;
    supp_nxt   = supp_r;
    tok_nxt    = tok_in;

    if (hit || alloc) begin
      key_nxt           = tok_in.key;
      start_nxt         = eff_start;
      tok_nxt.done      = 1'b1;
      tok_nxt.allocated = alloc;
      if (limit_hit) begin
        passed_nxt        = eff_passed;
        supp_nxt          = sat_inc32(cur_supp);
        tok_nxt.forward   = 1'b0;
        tok_nxt.held_back = 32'd0;
        tok_nxt.dropped   = 1'b1;
      end else begin
        passed_nxt        = eff_passed + 16'd1;
        supp_nxt          = 32'd0;
        tok_nxt.forward   = 1'b1;
        tok_nxt.held_back = cur_supp;
        tok_nxt.dropped   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    key_r    <= key_nxt;
    start_r  <= start_nxt;
    passed_r <= passed_nxt;
    supp_r   <= supp_nxt;
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule

`default_nettype wire

// File: design/keyed_window_rate_limiter_unit.sv
// Top level of the keyed window rate limiter: command interface, configuration
// registers, the row of slot cells and the result register.
// Depends on kwrl_pkg and kwrl_cell.
//
//   Channel   Ports                              Handshake
//   -------   --------------------------------   -------------------------------
//   request   start, busy, in_req                accepted when start && !busy
//   result    out_strobe, out_rsp                valid for the one strobe cycle
//   config    cfg_valid, cfg_ready, cfg_index,   written when cfg_valid && cfg_ready
//             cfg_data
//
// A request enters an entry register and then moves through one cell per clock,
// and the output of the last cell loads the result register and out_strobe.
// Busy falls at the edge where the result is taken, so the next request can
// be accepted only once the last result is out.
// Reset (rst_n low, synchronous) empties the table, clears the drop total and
// loads the register reset values; slot contents are left as they are.
// The receiver cannot stall: each result is shown for exactly one cycle.
`default_nettype none

module keyed_window_rate_limiter_unit
  import kwrl_pkg::*;
#(
  parameter int TABLE_ENTRIES = 16
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire in_req_t  in_req,
  output logic          out_strobe,
  output out_rsp_t      out_rsp,
  input  wire logic     cfg_valid,
  output logic          cfg_ready,
  input  wire cfg_idx_t cfg_index,
  input  wire [63:0]    cfg_data
);

  localparam int SU_W = $clog2(TABLE_ENTRIES + 1);

  cfg_regs_t       cfg_r, cfg_nxt;
  logic [SU_W-1:0] slots_used_r, slots_used_nxt;
  logic [31:0]     dropped_r, dropped_nxt;
  logic            busy_r, busy_nxt;
  logic            strobe_r, strobe_nxt;
  out_rsp_t        rsp_r, rsp_nxt;
  token_t          entry_r, entry_nxt;

  // Request positions along the row: index 0 is the entry register, index i+1
  // the output register of cell i.
  token_t tok [TABLE_ENTRIES+1];
  token_t last_tok;

  logic accept;

  assign accept    = start && !busy_r;
  assign cfg_ready = 1'b1;

  // Configuration writes; an index beyond the register list is ignored.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_IDX_MAX_PER_WINDOW: cfg_nxt.max_per_window = cfg_data[15:0];
        CFG_IDX_WINDOW_LENGTH:  cfg_nxt.window_length  = cfg_data;
        default: ;
      endcase
    end
  end

  // An unlimited event needs no slot, so it enters the row already answered.
  always_comb begin
    entry_nxt           = '0;
    entry_nxt.valid     = accept;
    entry_nxt.key       = {in_req.key_domain, in_req.key_code};
    entry_nxt.timestamp = in_req.timestamp;
    entry_nxt.done      = !in_req.is_limited;
    entry_nxt.forward   = 1'b1;
  end

  assign tok[0] = entry_r;

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    kwrl_cell #(
      .CELL_IDX (i),
      .SU_W     (SU_W)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cfg        (cfg_r),
      .slots_used (slots_used_r),
      .tok_in     (tok[i]),
      .tok_out    (tok[i+1])
    );
  end

  assign last_tok = tok[TABLE_ENTRIES];

  // A request that leaves the row unanswered found neither its key nor a free
  // slot, so it passes untracked.
  always_comb begin
    dropped_nxt    = dropped_r;
    slots_used_nxt = slots_used_r;
    rsp_nxt        = rsp_r;
    strobe_nxt     = last_tok.valid;
    if (last_tok.valid) begin
      if (last_tok.done && last_tok.dropped) begin
        dropped_nxt = sat_inc32(dropped_r);
      end
      if (last_tok.done && last_tok.allocated) begin
        slots_used_nxt = slots_used_r + SU_W'(1);
      end
      rsp_nxt.forward       = last_tok.done ? last_tok.forward : 1'b1;
      rsp_nxt.held_back     = last_tok.done ? last_tok.held_back : 32'd0;
      rsp_nxt.untracked     = !last_tok.done;
      rsp_nxt.total_dropped = dropped_nxt;
    end
  end

  // Busy from acceptance until the cycle after the result strobe.
  always_comb begin
    busy_nxt = busy_r;
    if (accept) begin
      busy_nxt = 1'b1;
    end else if (strobe_r) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_per_window <= MAX_PER_WINDOW_RST;
      cfg_r.window_length  <= WINDOW_LENGTH_RST;
      slots_used_r         <= '0;
      dropped_r            <= 32'd0;
      busy_r               <= 1'b0;
      strobe_r             <= 1'b0;
      entry_r.valid        <= 1'b0;
    end else begin
      cfg_r        <= cfg_nxt;
      slots_used_r <= slots_used_nxt;
      dropped_r    <= dropped_nxt;
      busy_r       <= busy_nxt;
      strobe_r     <= strobe_nxt;
      entry_r      <= entry_nxt;
    end
    rsp_r <= rsp_nxt;
  end

  assign busy       = busy_r;
  assign out_strobe = strobe_r;
  assign out_rsp    = rsp_r;

endmodule

`default_nettype wire

// File: design/kwrl_checker.sv
// Port-level checker for the keyed window rate limiter, bound to the top level.
// Depends on kwrl_pkg and keyed_window_rate_limiter_unit.
`default_nettype none

module kwrl_checker
  import kwrl_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     start,
  input wire logic     busy,
  input wire logic     out_strobe,
  input wire out_rsp_t out_rsp,
  input wire logic     cfg_ready
);

  // A result always belongs to a request still in flight.
  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> busy)
    else $error("result strobe while not busy");

  // Accepting a request makes the block busy and no result follows at once.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && !out_strobe))
    else $error("accepted request did not raise busy");

  // Exactly one result per request: the strobe is a single cycle and ends busy.
  a_strobe_once: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> (!out_strobe && !busy))
    else $error("result strobe repeated or busy held");

  // A dropped event never carries a held-back count or an untracked mark.
  a_drop_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_rsp.forward) |->
      (out_rsp.held_back == 32'd0 && !out_rsp.untracked && out_rsp.total_dropped != 32'd0))
    else $error("dropped event result inconsistent");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready)
    else $error("configuration port not ready");

endmodule

bind keyed_window_rate_limiter_unit kwrl_checker u_kwrl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_rsp    (out_rsp),
  .cfg_ready  (cfg_ready)
);

`default_nettype wire
